// ===== rtl/slc_pkg.sv =====
// Shared types and constants for the splat node level-of-detail and cone-cull block.
// Used by the divider pipeline and by the top level; depends on nothing.
package slc_pkg;

    // Default coordinate width used to sign-extend positions.
    localparam int COORD_BITS_DEF = 16;

    // Field widths.
    localparam int FIELD_W  = 16;
    localparam int CFG_W    = 48;
    localparam int DEPTH_W  = 6;
    localparam int MODE_W   = 6;
    localparam int THRESH_W = 15;
    localparam int ADDR_W   = 3;

    // Size division: numerator is radius * scale shifted left, quotient saturates.
    localparam int PROD_W    = 32;
    localparam int NUM_SHIFT = 15;
    localparam int DEN_W     = 35;
    localparam int QUOT_W    = 16;
    localparam int DIFF_W    = 18;
    localparam int DOT_W     = 34;
    localparam int DIST_W    = 36;

    // Fixed-point constants.
    localparam int ONE_Q14   = 16384;
    localparam int Q14_SHIFT = 14;
    localparam logic [QUOT_W-1:0] SIZE_DEFAULT = 16'd1024;
    localparam logic [QUOT_W-1:0] SIZE_SAT     = 16'hFFFF;

    // Mode flag bit positions.
    localparam int MODE_CULL     = 0;
    localparam int MODE_EDGES    = 1;
    localparam int MODE_PROJECT  = 2;
    localparam int MODE_ALWAYS   = 3;
    localparam int MODE_QUADS    = 4;
    localparam int MODE_QUADONLY = 5;

    // Configuration register reset values.
    localparam logic [CFG_W-1:0]    CAM_POS_RST   = 48'h0;
    localparam logic [CFG_W-1:0]    CAM_DIR_RST   = 48'h4000_0000_0000;
    localparam logic [FIELD_W-1:0]  SCALE_RST     = 16'd0;
    localparam logic [FIELD_W-1:0]  PIX_ERR_RST   = 16'd1024;
    localparam logic [FIELD_W-1:0]  PT_SIZE_RST   = 16'd16128;
    localparam logic [THRESH_W-1:0] THRESH_RST    = 15'd4915;
    localparam logic [DEPTH_W-1:0]  DEPTH_LIM_RST = 6'd63;
    localparam logic [MODE_W-1:0]   MODE_RST      = 6'd21;

    // Configuration register indexes.
    typedef enum logic [ADDR_W-1:0] {
        CFG_CAM_POS   = 3'd0,
        CFG_CAM_DIR   = 3'd1,
        CFG_SCALE     = 3'd2,
        CFG_PIX_ERR   = 3'd3,
        CFG_PT_SIZE   = 3'd4,
        CFG_THRESH    = 3'd5,
        CFG_DEPTH_LIM = 3'd6,
        CFG_MODE      = 3'd7
    } t_cfg_idx;

    // Node actions.
    typedef enum logic [1:0] {
        ACT_CULL    = 2'd0,
        ACT_DESCEND = 2'd1,
        ACT_POINT   = 2'd2,
        ACT_QUAD    = 2'd3
    } t_action;

    // Per-word information carried alongside the divider.
    typedef struct packed {
        logic               cull;
        logic               toward;
        logic               dist_pos;
        logic [DEPTH_W-1:0] depth;
        logic               children;
    } t_side;

endpackage

// ===== rtl/slc_div.sv =====
// Pipelined restoring divider with saturation for the projected screen size.
// One quotient bit per stage after an overflow stage; uses slc_pkg.
module slc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [slc_pkg::PROD_W-1:0] i_num,
    input  logic [slc_pkg::DEN_W-1:0]  i_den,
    input  slc_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [slc_pkg::QUOT_W-1:0] o_quot,
    output slc_pkg::t_side             o_side
);
    import slc_pkg::*;

    localparam int REM_W = DEN_W + QUOT_W + 1;

    logic [REM_W-1:0]  r_rem  [0:QUOT_W];
    logic [QUOT_W-1:0] r_quo  [0:QUOT_W];
    logic [DEN_W-1:0]  r_den  [0:QUOT_W];
    logic              r_ovf  [0:QUOT_W];
    t_side             r_side [0:QUOT_W];
    logic              r_vld  [0:QUOT_W];

    logic [REM_W-1:0] num_ext;
    logic [REM_W-1:0] den_top;

    // The quotient overflows 16 bits when the numerator reaches den << 16.
    assign num_ext = REM_W'({i_num, {NUM_SHIFT{1'b0}}});
    assign den_top = REM_W'({i_den, {QUOT_W{1'b0}}});

    // Overflow stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= num_ext;
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_ovf[0]  <= (num_ext >= den_top);
            r_side[0] <= i_side;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j <= QUOT_W; j++) begin : g_bit
        localparam int K = QUOT_W - j;
        logic [REM_W-1:0]  trial;
        logic              fits;
        logic [REM_W-1:0]  n_rem;
        logic [QUOT_W-1:0] n_quo;

        always_comb begin
            trial = REM_W'(r_den[j-1]) << K;
            fits  = (r_rem[j-1] >= trial);
            n_rem = fits ? (r_rem[j-1] - trial) : r_rem[j-1];
            n_quo = r_quo[j-1];
            n_quo[K] = fits;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_quo[j]  <= n_quo;
                r_den[j]  <= r_den[j-1];
                r_ovf[j]  <= r_ovf[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_vld[QUOT_W];
    assign o_quot  = r_ovf[QUOT_W] ? SIZE_SAT : r_quo[QUOT_W];
    assign o_side  = r_side[QUOT_W];

endmodule

// ===== rtl/splat_node_lod_cull_top.sv =====
// Splat node level-of-detail and normal-cone cull: top level; uses slc_pkg and slc_div.
// An accepted word passes through three arithmetic stages, seventeen divider stages
// (overflow plus one quotient bit each) and the output register on its way to a result.
// Throughput is one word per cycle; the whole pipeline holds while a result is stalled.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
module splat_node_lod_cull_top #(
    parameter int COORD_BITS = slc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_wr_en,
    input  logic [slc_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [slc_pkg::CFG_W-1:0]    i_cfg_wdata,
    // Node input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [15:0]           i_pos_x,
    input  logic signed [15:0]           i_pos_y,
    input  logic signed [15:0]           i_pos_z,
    input  logic signed [15:0]           i_normal_x,
    input  logic signed [15:0]           i_normal_y,
    input  logic signed [15:0]           i_normal_z,
    input  logic signed [15:0]           i_cone_cosine,
    input  logic [15:0]                  i_sphere_radius,
    input  logic [slc_pkg::DEPTH_W-1:0]  i_node_depth,
    input  logic                         i_cone_undecided,
    input  logic                         i_has_children,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_action,
    output logic                         o_cone_toward,
    output logic [15:0]                  o_proj_size
);
    import slc_pkg::*;

    // Positions above 16 bits wide read as unsigned; otherwise sign-extend from SB bits.
    localparam int SB = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam bit POS_UNSIGNED = (COORD_BITS > FIELD_W);

    // Configuration registers.
    logic [CFG_W-1:0]    r_cam_pos;
    logic [CFG_W-1:0]    r_cam_dir;
    logic [FIELD_W-1:0]  r_scale;
    logic [FIELD_W-1:0]  r_pix_err;
    logic [FIELD_W-1:0]  r_pt_size;
    logic [THRESH_W-1:0] r_thresh;
    logic [DEPTH_W-1:0]  r_depth_lim;
    logic [MODE_W-1:0]   r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos   <= CAM_POS_RST;
            r_cam_dir   <= CAM_DIR_RST;
            r_scale     <= SCALE_RST;
            r_pix_err   <= PIX_ERR_RST;
            r_pt_size   <= PT_SIZE_RST;
            r_thresh    <= THRESH_RST;
            r_depth_lim <= DEPTH_LIM_RST;
            r_mode      <= MODE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_CAM_POS:   r_cam_pos   <= i_cfg_wdata;
                CFG_CAM_DIR:   r_cam_dir   <= i_cfg_wdata;
                CFG_SCALE:     r_scale     <= i_cfg_wdata[FIELD_W-1:0];
                CFG_PIX_ERR:   r_pix_err   <= i_cfg_wdata[FIELD_W-1:0];
                CFG_PT_SIZE:   r_pt_size   <= i_cfg_wdata[FIELD_W-1:0];
                CFG_THRESH:    r_thresh    <= i_cfg_wdata[THRESH_W-1:0];
                CFG_DEPTH_LIM: r_depth_lim <= i_cfg_wdata[DEPTH_W-1:0];
                CFG_MODE:      r_mode      <= i_cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Camera fields.
    logic signed [FIELD_W-1:0] dir_x, dir_y, dir_z;
    logic signed [DIFF_W-1:0]  cam_x, cam_y, cam_z;

    assign dir_x = $signed(r_cam_dir[15:0]);
    assign dir_y = $signed(r_cam_dir[31:16]);
    assign dir_z = $signed(r_cam_dir[47:32]);
    assign cam_x = DIFF_W'($signed(r_cam_pos[SB-1:0]));
    assign cam_y = DIFF_W'($signed(r_cam_pos[16+SB-1:16]));
    assign cam_z = DIFF_W'($signed(r_cam_pos[32+SB-1:32]));

    // Pipeline advances unless a finished result is held.
    logic en;
    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // Stage 1: normal products, position offsets, numerator product.
    logic signed [DIFF_W-1:0] pos_x, pos_y, pos_z;

    assign pos_x = POS_UNSIGNED ? DIFF_W'($unsigned(i_pos_x)) : DIFF_W'($signed(i_pos_x[SB-1:0]));
    assign pos_y = POS_UNSIGNED ? DIFF_W'($unsigned(i_pos_y)) : DIFF_W'($signed(i_pos_y[SB-1:0]));
    assign pos_z = POS_UNSIGNED ? DIFF_W'($unsigned(i_pos_z)) : DIFF_W'($signed(i_pos_z[SB-1:0]));

    logic                       r1_vld;
    logic signed [31:0]         r1_np_x, r1_np_y, r1_np_z;
    logic signed [DIFF_W-1:0]   r1_df_x, r1_df_y, r1_df_z;
    logic [PROD_W-1:0]          r1_num;
    logic signed [FIELD_W-1:0]  r1_cone;
    logic [DEPTH_W-1:0]         r1_depth;
    logic                       r1_undec;
    logic                       r1_child;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_np_x  <= i_normal_x * dir_x;
            r1_np_y  <= i_normal_y * dir_y;
            r1_np_z  <= i_normal_z * dir_z;
            r1_df_x  <= pos_x - cam_x;
            r1_df_y  <= pos_y - cam_y;
            r1_df_z  <= pos_z - cam_z;
            r1_num   <= i_sphere_radius * r_scale;
            r1_cone  <= i_cone_cosine;
            r1_depth <= i_node_depth;
            r1_undec <= i_cone_undecided;
            r1_child <= i_has_children;
        end
    end

    // Stage 2: dot product sum and view-depth products.
    logic                       r2_vld;
    logic signed [DOT_W-1:0]    r2_dot;
    logic signed [DOT_W-1:0]    r2_dp_x, r2_dp_y, r2_dp_z;
    logic [PROD_W-1:0]          r2_num;
    logic signed [FIELD_W-1:0]  r2_cone;
    logic [DEPTH_W-1:0]         r2_depth;
    logic                       r2_undec;
    logic                       r2_child;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dot   <= DOT_W'(r1_np_x) + DOT_W'(r1_np_y) + DOT_W'(r1_np_z);
            r2_dp_x  <= dir_x * r1_df_x;
            r2_dp_y  <= dir_y * r1_df_y;
            r2_dp_z  <= dir_z * r1_df_z;
            r2_num   <= r1_num;
            r2_cone  <= r1_cone;
            r2_depth <= r1_depth;
            r2_undec <= r1_undec;
            r2_child <= r1_child;
        end
    end

    // Stage 3: cone tests and view depth sum.
    logic signed [DIST_W-1:0] dot_w;
    logic signed [16:0]       one_m_cone;
    logic signed [DIST_W-1:0] ddot;
    logic signed [DIST_W-1:0] thr;
    logic                     cone_test;
    logic                     away;
    logic                     edge_rej;
    logic                     n_cull;
    logic                     n_toward;

    always_comb begin
        dot_w      = DIST_W'(r2_dot);
        one_m_cone = 17'(ONE_Q14) - 17'(r2_cone);
        ddot       = DIST_W'(one_m_cone) <<< Q14_SHIFT;
        thr        = $signed(DIST_W'({r_thresh, {Q14_SHIFT{1'b0}}}));
        cone_test  = r_mode[MODE_CULL] && r2_undec;
        // Cone points wholly away from the viewer.
        away       = !dot_w[DIST_W-1] && (dot_w >= ddot);
        // In edge mode a cone facing far enough toward the viewer is rejected too.
        edge_rej   = r_mode[MODE_EDGES] && (dot_w <= 0) && (dot_w + ddot + thr <= 0);
        n_cull     = cone_test && (away || edge_rej);
        n_toward   = !r2_undec ||
                     (cone_test && !r_mode[MODE_EDGES] && !away &&
                      (dot_w <= 0) && (dot_w + ddot <= 0));
    end

    logic                     r3_vld;
    logic signed [DIST_W-1:0] r3_dist;
    logic [PROD_W-1:0]        r3_num;
    logic                     r3_cull;
    logic                     r3_toward;
    logic [DEPTH_W-1:0]       r3_depth;
    logic                     r3_child;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dist   <= DIST_W'(r2_dp_x) + DIST_W'(r2_dp_y) + DIST_W'(r2_dp_z);
            r3_num    <= r2_num;
            r3_cull   <= n_cull;
            r3_toward <= n_toward;
            r3_depth  <= r2_depth;
            r3_child  <= r2_child;
        end
    end

    // Divider pipeline for the projected size.
    t_side             div_side_in;
    t_side             div_side;
    logic              div_vld;
    logic [QUOT_W-1:0] div_quot;

    always_comb begin
        div_side_in.cull     = r3_cull;
        div_side_in.toward   = r3_toward;
        div_side_in.dist_pos = !r3_dist[DIST_W-1] && (r3_dist != '0);
        div_side_in.depth    = r3_depth;
        div_side_in.children = r3_child;
    end

    slc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_vld),
        .i_num   (r3_num),
        .i_den   (r3_dist[DEN_W-1:0]),
        .i_side  (div_side_in),
        .o_valid (div_vld),
        .o_quot  (div_quot),
        .o_side  (div_side)
    );

    // Output stage: pick the size and classify the node.
    logic [QUOT_W-1:0] size;
    logic              subdiv;
    t_action           n_action;
    logic [QUOT_W-1:0] n_size;

    always_comb begin
        if (!r_mode[MODE_PROJECT]) begin
            size = SIZE_DEFAULT;
        end else if (!div_side.dist_pos) begin
            size = SIZE_SAT;
        end else begin
            size = div_quot;
        end
        subdiv = div_side.children &&
                 (((div_side.depth <= r_depth_lim) && (size >= r_pix_err)) ||
                  r_mode[MODE_ALWAYS]);
        if (div_side.cull) begin
            n_action = ACT_CULL;
        end else if (subdiv) begin
            n_action = ACT_DESCEND;
        end else if (!r_mode[MODE_QUADONLY] && (!r_mode[MODE_QUADS] || (size < r_pt_size))) begin
            n_action = ACT_POINT;
        end else begin
            n_action = ACT_QUAD;
        end
        n_size = div_side.cull ? '0 : size;
    end

    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_action      <= n_action;
            o_cone_toward <= div_side.toward && !div_side.cull;
            o_proj_size   <= n_size;
        end
    end

    assign o_out_valid = r_out_vld;

`ifndef ASSERT_OFF
    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A held result must hold back new words.
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while result stalled");

    // Culled nodes carry no size and no cone mark.
    a_cull_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_CULL)) |-> ((o_proj_size == '0) && !o_cone_toward))
        else $error("culled node with nonzero size or cone mark");

    // Without projection every drawn or descended node has the default size.
    a_default_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_mode[MODE_PROJECT] && (o_action != ACT_CULL))
        |-> (o_proj_size == SIZE_DEFAULT))
        else $error("unprojected size differs from default");
`endif

endmodule

// ===== bench/tb_splat_node_lod_cull_top.sv =====
`timescale 1ns / 1ps
// Testbench for splat_node_lod_cull_top: a directed stimulus table, then random nodes
// under several register settings, each result checked against its typed expectation or a built-in classifier.
// Depends on rtl/slc_pkg.sv and rtl/splat_node_lod_cull_top.sv.
module tb_splat_node_lod_cull_top;
    import slc_pkg::*;

    // One input word: a node of the sphere hierarchy.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic signed [15:0] cone_cos;
        logic [15:0]        radius;
        logic [DEPTH_W-1:0] depth;
        logic               undecided;
        logic               children;
    } t_node;

    // One result word.
    typedef struct packed {
        t_action     action;
        logic        toward;
        logic [15:0] size;
    } t_node_result;

    // A row of the directed table: either a register write or a node.
    typedef struct packed {
        logic             is_reg;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] val;
        t_node            n;
        logic             typed;
        t_node_result     r;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic signed [15:0]  i_pos_x = '0;
    logic signed [15:0]  i_pos_y = '0;
    logic signed [15:0]  i_pos_z = '0;
    logic signed [15:0]  i_normal_x = '0;
    logic signed [15:0]  i_normal_y = '0;
    logic signed [15:0]  i_normal_z = '0;
    logic signed [15:0]  i_cone_cosine = '0;
    logic [15:0]         i_sphere_radius = '0;
    logic [DEPTH_W-1:0]  i_node_depth = '0;
    logic                i_cone_undecided = 1'b0;
    logic                i_has_children = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [1:0]          o_action;
    logic                o_cone_toward;
    logic [15:0]         o_proj_size;

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0]    cam_pos = CAM_POS_RST;
    logic [CFG_W-1:0]    cam_dir = CAM_DIR_RST;
    logic [15:0]         scr_scale = SCALE_RST;
    logic [15:0]         pix_err = PIX_ERR_RST;
    logic [15:0]         pt_size = PT_SIZE_RST;
    logic [THRESH_W-1:0] sil_thr = THRESH_RST;
    logic [DEPTH_W-1:0]  depth_lim = DEPTH_LIM_RST;
    logic [MODE_W-1:0]   mode = MODE_RST;

    t_node_result pending_results [$];
    t_dir_row     directed_rows [$];
    t_node_result head;
    int           mismatch_count = 0;
    int           stall_left = 0;
    bit           rx_quiet = 1'b0;

    splat_node_lod_cull_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_normal_z       (i_normal_z),
        .i_cone_cosine    (i_cone_cosine),
        .i_sphere_radius  (i_sphere_radius),
        .i_node_depth     (i_node_depth),
        .i_cone_undecided (i_cone_undecided),
        .i_has_children   (i_has_children),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_action         (o_action),
        .o_cone_toward    (o_cone_toward),
        .o_proj_size      (o_proj_size)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Classify one node against the current register settings.
    function automatic t_node_result classify_node(input t_node n);
        longint       pos [3];
        longint       nrm [3];
        longint       cam [3];
        longint       dir [3];
        longint       cone, dot, ddot, thr, view_depth, num, rad, scl, size;
        logic         culled;
        int           i;
        t_node_result res;
        pos[0] = $signed(n.pos_x);
        pos[1] = $signed(n.pos_y);
        pos[2] = $signed(n.pos_z);
        nrm[0] = $signed(n.nrm_x);
        nrm[1] = $signed(n.nrm_y);
        nrm[2] = $signed(n.nrm_z);
        for (i = 0; i < 3; i++) begin
            cam[i] = $signed(cam_pos[16*i +: 16]);
            dir[i] = $signed(cam_dir[16*i +: 16]);
        end
        cone = $signed(n.cone_cos);
        res.toward = !n.undecided;

        // Normal-cone test, only while the parent left the cone open.
        if (mode[MODE_CULL] && n.undecided) begin
            dot = nrm[0] * dir[0] + nrm[1] * dir[1] + nrm[2] * dir[2];
            ddot = (ONE_Q14 - cone) * ONE_Q14;
            culled = (dot >= 0) && (dot - ddot >= 0);
            if (mode[MODE_EDGES]) begin
                thr = sil_thr;
                thr = thr * ONE_Q14;
                if (dot <= 0 && dot + ddot <= -thr)
                    culled = 1'b1;
            end else if (!culled && dot <= 0 && dot + ddot <= 0) begin
                res.toward = 1'b1;
            end
            if (culled) begin
                res.action = ACT_CULL;
                res.toward = 1'b0;
                res.size = '0;
                return res;
            end
        end

        // Projected size, saturated when the node is not in front of the camera.
        if (mode[MODE_PROJECT]) begin
            view_depth = 0;
            for (i = 0; i < 3; i++)
                view_depth += dir[i] * (pos[i] - cam[i]);
            if (view_depth <= 0) begin
                size = SIZE_SAT;
            end else begin
                rad = n.radius;
                scl = scr_scale;
                num = (rad * scl) << NUM_SHIFT;
                size = num / view_depth;
                if (size > 65535)
                    size = SIZE_SAT;
            end
        end else begin
            size = SIZE_DEFAULT;
        end
        res.size = size[15:0];

        if (n.children && ((n.depth <= depth_lim && size >= pix_err) || mode[MODE_ALWAYS]))
            res.action = ACT_DESCEND;
        else if (!mode[MODE_QUADONLY] && (!mode[MODE_QUADS] || size < pt_size))
            res.action = ACT_POINT;
        else
            res.action = ACT_QUAD;
        return res;
    endfunction

    function automatic t_node mk_node(input int px, input int py, input int pz,
                                      input int nx, input int ny, input int nz,
                                      input int cc, input int rad, input int dep,
                                      input int und, input int chl);
        t_node n;
        n.pos_x = px[15:0];
        n.pos_y = py[15:0];
        n.pos_z = pz[15:0];
        n.nrm_x = nx[15:0];
        n.nrm_y = ny[15:0];
        n.nrm_z = nz[15:0];
        n.cone_cos = cc[15:0];
        n.radius = rad[15:0];
        n.depth = dep[DEPTH_W-1:0];
        n.undecided = und[0];
        n.children = chl[0];
        return n;
    endfunction

    function automatic void add_node(input t_node n);
        t_dir_row row;
        row = '0;
        row.n = n;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_typed(input t_node n, input t_node_result r);
        t_dir_row row;
        row = '0;
        row.n = n;
        row.typed = 1'b1;
        row.r = r;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        t_dir_row row;
        row = '0;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.val = v;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Random node: normals in range for half the draws, else axis-aligned or raw bits.
    function automatic t_node rand_node();
        t_node       n;
        logic [15:0] unit_val;
        n.pos_x = 16'($urandom);
        n.pos_y = 16'($urandom);
        n.pos_z = 16'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                n.nrm_x = '0;
                n.nrm_y = '0;
                n.nrm_z = '0;
                unit_val = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
                case ($urandom_range(0, 2))
                    0: n.nrm_x = unit_val;
                    1: n.nrm_y = unit_val;
                    default: n.nrm_z = unit_val;
                endcase
            end
            1: begin
                n.nrm_x = 16'($urandom);
                n.nrm_y = 16'($urandom);
                n.nrm_z = 16'($urandom);
            end
            default: begin
                n.nrm_x = 16'($urandom_range(0, 2 * ONE_Q14) - ONE_Q14);
                n.nrm_y = 16'($urandom_range(0, 2 * ONE_Q14) - ONE_Q14);
                n.nrm_z = 16'($urandom_range(0, 2 * ONE_Q14) - ONE_Q14);
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            n.cone_cos = 16'($urandom);
        else
            n.cone_cos = 16'($urandom_range(0, 2 * ONE_Q14) - ONE_Q14);
        n.radius = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1023));
        n.depth = DEPTH_W'($urandom);
        n.undecided = 1'($urandom);
        n.children = 1'($urandom);
        return n;
    endfunction

    // Drop valid and wait until every expected result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Write one register; the caller lowers the write enable when done.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        case (idx)
            CFG_CAM_POS:   cam_pos = v;
            CFG_CAM_DIR:   cam_dir = v;
            CFG_SCALE:     scr_scale = v[15:0];
            CFG_PIX_ERR:   pix_err = v[15:0];
            CFG_PT_SIZE:   pt_size = v[15:0];
            CFG_THRESH:    sil_thr = v[THRESH_W-1:0];
            CFG_DEPTH_LIM: depth_lim = v[DEPTH_W-1:0];
            CFG_MODE:      mode = v[MODE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Present one node word after a gap and hold it until it is taken.
    task automatic drive_node(input t_node n, input t_node_result want, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x <= n.pos_x;
        i_pos_y <= n.pos_y;
        i_pos_z <= n.pos_z;
        i_normal_x <= n.nrm_x;
        i_normal_y <= n.nrm_y;
        i_normal_z <= n.nrm_z;
        i_cone_cosine <= n.cone_cos;
        i_sphere_radius <= n.radius;
        i_node_depth <= n.depth;
        i_cone_undecided <= n.undecided;
        i_has_children <= n.children;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_results.insert(pending_results.size(), want);
    endtask

    // Result side: check each accepted word, then draw the stall before the next one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation pending");
                mismatch_count++;
            end else begin
                head = pending_results.pop_front();
                if (o_action !== head.action) begin
                    $error("action: expected %0d, got %0d", head.action, o_action);
                    mismatch_count++;
                end
                if (o_cone_toward !== head.toward) begin
                    $error("cone_toward: expected %0d, got %0d", head.toward, o_cone_toward);
                    mismatch_count++;
                end
                if (o_proj_size !== head.size) begin
                    $error("proj_size: expected %0d, got %0d", head.size, o_proj_size);
                    mismatch_count++;
                end
            end
            stall_left = rx_quiet ? 0 : int'($urandom_range(0, 9));
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Stimulus: directed table first, then randomized phases.
    initial begin
        t_node            n;
        t_dir_row         row;
        logic [CFG_W-1:0] v;
        logic [15:0]      unit_val;
        int               ph, k, r;
        logic             quiet;

        // Reset defaults: culling, projection and quads on, camera looking down +z.
        add_typed(mk_node(0, 0, 256, 0, 0, 16384, 16384, 256, 1, 1, 1),
                  '{ACT_CULL, 1'b0, 16'd0});
        add_typed(mk_node(0, 0, 256, 0, 0, -16384, 16384, 256, 1, 1, 1),
                  '{ACT_POINT, 1'b1, 16'd0});
        add_typed(mk_node(0, 0, 0, 0, 0, 0, 0, 256, 5, 0, 1),
                  '{ACT_DESCEND, 1'b1, 16'hFFFF});
        add_typed(mk_node(32767, 32767, -32768, 0, 0, 0, 0, 65535, 63, 0, 0),
                  '{ACT_QUAD, 1'b1, 16'hFFFF});
        add_typed(mk_node(-32768, 0, 0, 0, 0, 0, 0, 0, 63, 0, 1),
                  '{ACT_DESCEND, 1'b1, 16'hFFFF});
        add_node(mk_node(-32768, -32768, 0, -32768, 32767, -32768, -32768, 65535, 0, 1, 1));
        add_node(mk_node(0, 0, 32767, 16384, 16384, 16384, 32767, 1, 2, 1, 0));
        add_node(mk_node(0, 0, 100, 0, 0, 16384, -16384, 300, 3, 1, 1));
        // Widest screen: sizes reach saturation.
        add_reg(CFG_SCALE, 48'hFFFF);
        add_node(mk_node(0, 0, 1, 0, 0, 0, 0, 65535, 1, 0, 1));
        add_node(mk_node(0, 0, 32767, 0, 0, 0, 0, 1, 1, 0, 1));
        // Silhouette-edge mode rejects cones facing the viewer.
        add_reg(CFG_MODE, 48'd7);
        add_typed(mk_node(0, 0, 256, 0, 0, -16384, 16384, 256, 1, 1, 1),
                  '{ACT_CULL, 1'b0, 16'd0});
        add_node(mk_node(0, 0, 256, 0, 0, -16384, 0, 256, 1, 1, 1));
        add_reg(CFG_THRESH, 48'd0);
        add_node(mk_node(0, 0, 256, 0, 0, -16384, 0, 256, 1, 1, 1));
        add_reg(CFG_THRESH, 48'd16384);
        add_node(mk_node(0, 0, 256, 0, 0, -16384, -16384, 256, 1, 1, 0));
        // Size not projected: fixed default size.
        add_reg(CFG_MODE, 48'd1);
        add_typed(mk_node(123, -456, 789, 0, 0, 0, 0, 500, 9, 0, 0),
                  '{ACT_POINT, 1'b1, 16'd1024});
        // Always subdivide with quads only, no culling.
        add_reg(CFG_MODE, 48'd40);
        add_typed(mk_node(0, 0, 256, 0, 0, 16384, 16384, 256, 10, 1, 1),
                  '{ACT_DESCEND, 1'b0, 16'd1024});
        add_typed(mk_node(0, 0, 256, 0, 0, 16384, 16384, 256, 10, 0, 0),
                  '{ACT_QUAD, 1'b1, 16'd1024});
        // Depth limit at its floor, camera moved and turned to -x.
        add_reg(CFG_DEPTH_LIM, 48'd0);
        add_reg(CFG_MODE, 48'd20);
        add_node(mk_node(0, 0, 1, 0, 0, 0, 0, 65535, 1, 0, 1));
        add_reg(CFG_CAM_POS, 48'h0100_FF00_0200);
        add_reg(CFG_CAM_DIR, 48'h0000_0000_C000);
        add_node(mk_node(-2000, 50, 60, 0, 0, 0, 0, 4000, 0, 1, 1));
        add_reg(CFG_PIX_ERR, 48'd0);
        add_reg(CFG_PT_SIZE, 48'd0);
        add_node(mk_node(-300, 0, 0, 0, 0, 0, 0, 4000, 0, 1, 1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_reg) begin
                wait_idle();
                write_reg(row.idx, row.val);
            end else begin
                i_cfg_wr_en <= 1'b0;
                drive_node(row.n, row.typed ? row.r : classify_node(row.n),
                           $urandom_range(0, 9));
            end
        end

        // Random phases: first all registers at their top (the threshold at ONE_Q14), then all at zero.
        for (ph = 0; ph < 10; ph++) begin
            wait_idle();
            for (r = 0; r < 8; r++) begin
                if (ph == 1) begin
                    v = '0;
                end else if (ph == 0) begin
                    v = (t_cfg_idx'(r) == CFG_THRESH) ? CFG_W'(ONE_Q14) : '1;
                end else begin
                    case (t_cfg_idx'(r))
                        CFG_CAM_DIR: begin
                            if ($urandom_range(0, 3) == 0) begin
                                v = CFG_W'({$urandom, $urandom});
                            end else begin
                                unit_val = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
                                v = CFG_W'(unit_val) << (16 * $urandom_range(0, 2));
                            end
                        end
                        CFG_PIX_ERR, CFG_PT_SIZE:
                            v = CFG_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
                        CFG_THRESH: v = CFG_W'($urandom_range(0, ONE_Q14));
                        default:    v = CFG_W'({$urandom, $urandom});
                    endcase
                end
                write_reg(t_cfg_idx'(r), v);
            end
            i_cfg_wr_en <= 1'b0;

            // Every third phase runs back to back on both sides.
            quiet = (ph % 3 == 2);
            rx_quiet = quiet;
            for (k = 0; k < 45; k++) begin
                // Let the pipeline drain completely once in mid-phase.
                if (ph == 4 && k == 20)
                    wait_idle();
                n = rand_node();
                drive_node(n, classify_node(n), quiet ? 0 : $urandom_range(0, 9));
            end
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== splat_node_lod_cull_top.f =====
rtl/slc_pkg.sv
rtl/slc_div.sv
rtl/splat_node_lod_cull_top.sv
bench/tb_splat_node_lod_cull_top.sv
